>>> sv/gid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_pkg: shared types and constants of the pixel group decoder
// Beat layouts, sequencer codes and the group byte mask.
// ----------------------------------------------------------------------------
package gid_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int GROUP_PIXELS = 4;
    localparam int ROW_AW       = $clog2(MAX_ROWS);
    localparam int MAX_WIDTH    = 4096;

    localparam int WIDTH_W = 13;
    localparam int HEIGHT_W = 11;
    localparam int PIX_W   = 8;
    localparam int COL_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CFG_AW  = 2;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_BYTE  = 2'd3
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WHITE  = 2'd2,
        CFG_BLACK  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_MARK0 = 2'd0,
        PH_MARK1 = 2'd1,
        PH_RAW   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [ROW_AW-1:0] row_index;
        logic [7:0]        byte_value;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  pixel_a;
        logic [PIX_W-1:0]  pixel_b;
        logic [PIX_W-1:0]  pixel_c;
        logic [PIX_W-1:0]  pixel_d;
        logic [2:0]        group_size;
        logic [ROW_AW-1:0] out_row;
        logic [COL_W-1:0]  out_column;
        logic [ROW_AW:0]   run_length;
        logic              frame_done;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
        logic [PIX_W-1:0]    white_value;
        logic [PIX_W-1:0]    black_value;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        logic              clear;
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
    } t_map_ctl;

    typedef struct packed {
        logic emit;
        logic flush;
        logic mark_fd;
    } t_ost_ctl;

    // Keep only the bytes of a group that lie inside the row.
    function automatic logic [4*PIX_W-1:0] group_mask(input logic [2:0] size);
        logic [4*PIX_W-1:0] m;
        case (size)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> sv/bitpacked_group_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitpacked_group_image_decoder: prefix coded pixel group decoder
// Turns an MSB-first bit stream into groups of up to four 8-bit pixels and
// reports runs of rows marked empty.
// ----------------------------------------------------------------------------
// Works on one input beat at a time. A compressed byte is accepted, walked
// bit by bit through the mark and raw byte decoder, and its final result is
// then released. A dropped byte (no frame open) and a mark beat are done on
// acceptance; a start frame beat goes on to scan the bitmap from row 0.
// Reaching a new row scans the empty row bitmap, each row examined by a
// registered memory read and then a check, and a closing step ends the scan.
// A clear beat and reset each sweep the bitmap, one row per cycle, over every
// row, during which no input beat is accepted. Configuration writes are
// taken at any time, but width and height only act from the next start frame
// beat. Each result waits in a holding register until the decoder knows
// whether it is the last one of its input beat; it then moves to the output
// register. While that register is full and stalled the decoder waits, and
// the input stays stalled with it.
// ----------------------------------------------------------------------------
module bitpacked_group_image_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [gid_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [gid_pkg::CFG_W-1:0]  i_cfg_data,
    // input beats
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gid_pkg::t_in_item          i_in_data,
    // result beats
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gid_pkg::t_out_item         o_out_data
);
    import gid_pkg::*;

    t_cfg      r_cfg;
    logic      w_core_ready;
    t_map_ctl  w_map_ctl;
    logic      w_map_data;
    logic      w_map_busy;
    t_ost_ctl  w_ost_ctl;
    t_out_item w_item;
    logic      w_ost_ready;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= WIDTH_W'(1);
            r_cfg.image_height <= HEIGHT_W'(1);
            r_cfg.white_value  <= 8'hFF;
            r_cfg.black_value  <= 8'h00;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_cfg.image_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_WHITE:  r_cfg.white_value  <= i_cfg_data[PIX_W-1:0];
                CFG_BLACK:  r_cfg.black_value  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Stall input beats while a beat is in work or the bitmap is sweeping.
    assign o_in_stall = ~w_core_ready;

    gid_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_ready     (w_core_ready),
        .o_map       (w_map_ctl),
        .i_map_data  (w_map_data),
        .i_map_busy  (w_map_busy),
        .o_ost       (w_ost_ctl),
        .o_item      (w_item),
        .i_ost_ready (w_ost_ready)
    );

    // Empty row bitmap with its clearing sweep.
    gid_row_map u_row_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_map_ctl),
        .o_rd_data (w_map_data),
        .o_busy    (w_map_busy)
    );

    // Holding register for the last flag, then the output register.
    gid_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ost_ctl),
        .i_item      (w_item),
        .o_ready     (w_ost_ready),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/gid_row_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_row_map: empty row bitmap
// One bit per row, one write and one registered read per cycle; a clearing
// sweep runs after reset and on request.
// ----------------------------------------------------------------------------
module gid_row_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gid_pkg::t_map_ctl i_ctl,
    output logic              o_rd_data,
    output logic              o_busy
);
    import gid_pkg::*;

    logic                r_mem [MAX_ROWS];
    logic                r_rd_data;
    logic                r_busy;
    logic [ROW_AW-1:0]   r_clr_addr;
    logic                n_busy;
    logic [ROW_AW-1:0]   n_clr_addr;
    logic                w_we;
    logic [ROW_AW-1:0]   w_addr;
    logic                w_data;

    always_comb begin
        n_busy     = r_busy;
        n_clr_addr = r_clr_addr;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == ROW_AW'(MAX_ROWS - 1)) begin
                n_busy = 1'b0;
            end
        end else if (i_ctl.clear) begin
            n_busy     = 1'b1;
            n_clr_addr = '0;
        end
    end

    // sweep owns the write port while it runs
    assign w_we   = r_busy | i_ctl.wr_en;
    assign w_addr = r_busy ? r_clr_addr : i_ctl.wr_addr;
    assign w_data = ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

>>> sv/gid_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_out_stage: result holding and output register
// Hold the newest result until the next one or the end of the input decides
// its last flag, then move it to the output register.
// ----------------------------------------------------------------------------
module gid_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gid_pkg::t_ost_ctl  i_ctl,
    input  gid_pkg::t_out_item i_item,
    output logic               o_ready,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output gid_pkg::t_out_item o_out_data
);
    import gid_pkg::*;

    logic      r_pend_valid, n_pend_valid;
    t_out_item r_pend, n_pend;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    assign o_ready = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out        = r_out;
        if (i_ctl.emit) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
            n_pend       = i_item;
            n_pend_valid = 1'b1;
        end else if (i_ctl.flush) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out.last  = 1'b1;
                n_out_valid = 1'b1;
            end
            n_pend_valid = 1'b0;
        end else if (i_ctl.mark_fd && r_pend_valid) begin
            n_pend.frame_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/gid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_core: bit sequencer of the decoder
// Walk a byte one bit per cycle, but for output stalls and row scans, through
// the mark and raw byte decoder and scan empty rows through the row map.
// ----------------------------------------------------------------------------
module gid_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gid_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  gid_pkg::t_in_item  i_in_data,
    output logic               o_ready,
    output gid_pkg::t_map_ctl  o_map,
    input  logic               i_map_data,
    input  logic               i_map_busy,
    output gid_pkg::t_ost_ctl  o_ost,
    output gid_pkg::t_out_item o_item,
    input  logic               i_ost_ready
);
    import gid_pkg::*;

    t_state              r_state, n_state;
    logic [WIDTH_W-1:0]  r_lat_w, n_lat_w;
    logic [HEIGHT_W-1:0] r_lat_h, n_lat_h;
    t_phase              r_phase, n_phase;
    logic [7:0]          r_shift, n_shift;
    logic [2:0]          r_taken, n_taken;
    logic [31:0]         r_store, n_store;
    logic [2:0]          r_filled, n_filled;
    logic [ROW_AW:0]     r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_frame_over, n_frame_over;
    logic [7:0]          r_byte, n_byte;
    logic [3:0]          r_bits_left, n_bits_left;
    logic [ROW_AW-1:0]   r_run_start, n_run_start;
    logic [ROW_AW:0]     r_run_cnt, n_run_cnt;

    logic                w_accept;
    logic                w_bit;
    logic [WIDTH_W-1:0]  w_rem;
    logic [2:0]          w_size;
    logic [7:0]          w_new_shift;
    logic [31:0]         w_raw;
    logic [WIDTH_W-1:0]  w_col_next;
    logic                w_row_end;
    logic                w_fin;
    logic [31:0]         w_pix;
    logic                w_done;
    logic [ROW_AW:0]     w_row_inc;

    assign o_ready  = (r_state == ST_IDLE) & ~i_map_busy;
    assign w_accept = o_ready & i_in_valid;

    assign w_bit       = r_byte[7];
    assign w_rem       = r_lat_w - WIDTH_W'(r_col);
    assign w_size      = (w_rem < WIDTH_W'(GROUP_PIXELS)) ? w_rem[2:0] : 3'(GROUP_PIXELS);
    assign w_new_shift = {r_shift[6:0], w_bit};
    assign w_raw       = r_store | ({24'b0, w_new_shift} << {r_filled[1:0], 3'b000});
    assign w_col_next  = WIDTH_W'(r_col) + WIDTH_W'(w_size);
    assign w_row_end   = w_col_next >= r_lat_w;
    assign w_done      = r_row >= r_lat_h;
    assign w_row_inc   = r_row + 1'b1;

    always_comb begin
        case (r_phase)
            PH_MARK0: begin
                w_fin = ~w_bit;
                w_pix = {4{i_cfg.white_value}};
            end
            PH_MARK1: begin
                w_fin = ~w_bit;
                w_pix = {4{i_cfg.black_value}};
            end
            default: begin
                w_fin = (r_taken == 3'd7) & ({1'b0, r_filled} + 4'd1 >= {1'b0, w_size});
                w_pix = w_raw;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_lat_w      = r_lat_w;
        n_lat_h      = r_lat_h;
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_taken      = r_taken;
        n_store      = r_store;
        n_filled     = r_filled;
        n_row        = r_row;
        n_col        = r_col;
        n_frame_over = r_frame_over;
        n_byte       = r_byte;
        n_bits_left  = r_bits_left;
        n_run_start  = r_run_start;
        n_run_cnt    = r_run_cnt;
        o_map        = '0;
        o_ost        = '0;
        o_item       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_in_data.op))
                        OP_MARK: begin
                            o_map.wr_en   = 1'b1;
                            o_map.wr_addr = i_in_data.row_index;
                        end
                        OP_CLEAR: begin
                            o_map.clear = 1'b1;
                        end
                        OP_START: begin
                            if (i_cfg.image_width == '0) begin
                                n_lat_w = WIDTH_W'(1);
                            end else if (i_cfg.image_width > WIDTH_W'(MAX_WIDTH)) begin
                                n_lat_w = WIDTH_W'(MAX_WIDTH);
                            end else begin
                                n_lat_w = i_cfg.image_width;
                            end
                            if (i_cfg.image_height == '0) begin
                                n_lat_h = HEIGHT_W'(1);
                            end else if (i_cfg.image_height > HEIGHT_W'(MAX_ROWS)) begin
                                n_lat_h = HEIGHT_W'(MAX_ROWS);
                            end else begin
                                n_lat_h = i_cfg.image_height;
                            end
                            n_phase      = PH_MARK0;
                            n_shift      = '0;
                            n_taken      = '0;
                            n_store      = '0;
                            n_filled     = '0;
                            n_row        = '0;
                            n_col        = '0;
                            n_frame_over = 1'b0;
                            n_bits_left  = '0;
                            n_run_start  = '0;
                            n_run_cnt    = '0;
                            n_state      = ST_SCAN_RD;
                        end
                        OP_BYTE: begin
                            // drop bytes outside a frame
                            if (!r_frame_over) begin
                                n_byte      = i_in_data.byte_value;
                                n_bits_left = 4'd8;
                                n_state     = ST_BIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_BIT: begin
                // hold the bit while a finished group cannot be emitted
                if (!w_fin || i_ost_ready) begin
                    n_byte      = {r_byte[6:0], 1'b0};
                    n_bits_left = r_bits_left - 1'b1;
                    n_state     = (r_bits_left == 4'd1) ? ST_FLUSH : ST_BIT;
                    if (w_fin) begin
                        o_ost.emit        = 1'b1;
                        o_item.kind       = 1'b0;
                        {o_item.pixel_d, o_item.pixel_c, o_item.pixel_b,
                         o_item.pixel_a}  = w_pix & group_mask(w_size);
                        o_item.group_size = w_size;
                        o_item.out_row    = r_row[ROW_AW-1:0];
                        o_item.out_column = r_col;
                        n_phase  = PH_MARK0;
                        n_shift  = '0;
                        n_taken  = '0;
                        n_store  = '0;
                        n_filled = '0;
                        n_col    = w_col_next[COL_W-1:0];
                        if (w_row_end) begin
                            n_col       = '0;
                            n_row       = w_row_inc;
                            n_run_start = w_row_inc[ROW_AW-1:0];
                            n_run_cnt   = '0;
                            n_state     = ST_SCAN_RD;
                        end
                    end else begin
                        case (r_phase)
                            PH_MARK0: begin
                                n_phase = PH_MARK1;
                            end
                            PH_MARK1: begin
                                n_phase  = PH_RAW;
                                n_shift  = '0;
                                n_taken  = '0;
                                n_store  = '0;
                                n_filled = '0;
                            end
                            default: begin
                                n_shift = w_new_shift;
                                if (r_taken != 3'd7) begin
                                    n_taken = r_taken + 1'b1;
                                end else begin
                                    n_taken  = '0;
                                    n_store  = w_raw;
                                    n_filled = r_filled + 1'b1;
                                    n_shift  = '0;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_SCAN_RD: begin
                if (!w_done) begin
                    o_map.rd_en   = 1'b1;
                    o_map.rd_addr = r_row[ROW_AW-1:0];
                    n_state       = ST_SCAN_CHK;
                end else begin
                    n_state = ST_SCAN_END;
                end
            end

            ST_SCAN_CHK: begin
                if (i_map_data) begin
                    n_row     = w_row_inc;
                    n_run_cnt = r_run_cnt + 1'b1;
                    n_state   = ST_SCAN_RD;
                end else begin
                    n_state = ST_SCAN_END;
                end
            end

            ST_SCAN_END: begin
                if (r_run_cnt == '0 || i_ost_ready) begin
                    if (r_run_cnt != '0) begin
                        o_ost.emit        = 1'b1;
                        o_item.kind       = 1'b1;
                        o_item.out_row    = r_run_start;
                        o_item.run_length = r_run_cnt;
                        o_item.frame_done = w_done;
                    end else begin
                        o_ost.mark_fd = w_done;
                    end
                    if (w_done) begin
                        n_frame_over = 1'b1;
                    end
                    n_state = (w_done || r_bits_left == '0) ? ST_FLUSH : ST_BIT;
                end
            end

            ST_FLUSH: begin
                if (i_ost_ready) begin
                    o_ost.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lat_w      <= WIDTH_W'(1);
            r_lat_h      <= HEIGHT_W'(1);
            r_phase      <= PH_MARK0;
            r_shift      <= '0;
            r_taken      <= '0;
            r_store      <= '0;
            r_filled     <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_frame_over <= 1'b1;
            r_bits_left  <= '0;
            r_run_start  <= '0;
            r_run_cnt    <= '0;
        end else begin
            r_state      <= n_state;
            r_lat_w      <= n_lat_w;
            r_lat_h      <= n_lat_h;
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_taken      <= n_taken;
            r_store      <= n_store;
            r_filled     <= n_filled;
            r_row        <= n_row;
            r_col        <= n_col;
            r_frame_over <= n_frame_over;
            r_bits_left  <= n_bits_left;
            r_run_start  <= n_run_start;
            r_run_cnt    <= n_run_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule
